// File: rtl/mctt_pkg.sv
// Shared types, constants and codes for the MIDI clock tempo tracker.
package mctt_pkg;

    localparam int HISTORY_DEPTH_DEFAULT = 24;

    localparam int TIME_W     = 32;
    localparam int TEMPO_W    = 10;
    localparam int MEAS_W     = 15;
    localparam int DIVIDEND_W = 22;
    localparam int DIVISOR_W  = 32;
    localparam int DIV_STEP_W = $clog2(DIVIDEND_W + 1);

    localparam logic [MEAS_W-1:0]     MEAS_MAX       = 15'd32767;
    localparam logic [DIVIDEND_W-1:0] US_PER_QUARTER = 22'd2500000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMPO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMPO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_TIMEOUT = 2'd2;

    localparam logic [TEMPO_W-1:0] MIN_TEMPO_RST = 10'd30;
    localparam logic [TEMPO_W-1:0] MAX_TEMPO_RST = 10'd300;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST   = 32'd500000;

    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] time_us;
    } in_item_t;

    typedef struct packed {
        logic               clock_present;
        logic               tempo_updated;
        logic [TEMPO_W-1:0] tempo;
    } out_item_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAS,
        ST_SUM,
        ST_SUM_TAIL,
        ST_AVG,
        ST_DONE
    } state_t;

endpackage

// File: rtl/mctt_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
module mctt_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  mctt_pkg::div_req_t req,
    output mctt_pkg::div_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [mctt_pkg::DIV_STEP_W-1:0]     step_reg, step_next;
    logic [mctt_pkg::DIVISOR_W-1:0]      rem_reg, rem_next;
    logic [mctt_pkg::DIVIDEND_W-1:0]     quo_reg, quo_next;
    logic [mctt_pkg::DIVISOR_W-1:0]      divisor_reg, divisor_next;
    logic [mctt_pkg::DIVISOR_W:0]        rem_shift;
    logic                                fits;

    assign rem_shift = {rem_reg, quo_reg[mctt_pkg::DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            step_next    = mctt_pkg::DIV_STEP_W'(mctt_pkg::DIVIDEND_W);
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = mctt_pkg::DIVISOR_W'(rem_shift - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = rem_shift[mctt_pkg::DIVISOR_W-1:0];
            end
            quo_next  = {quo_reg[mctt_pkg::DIVIDEND_W-2:0], fits};
            step_next = step_reg - mctt_pkg::DIV_STEP_W'(1);
            if (step_reg == mctt_pkg::DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: rtl/mctt_ring.sv
// Measurement history memory with one write port and one registered read port.
module mctt_ring
#(
    parameter int DEPTH  = mctt_pkg::HISTORY_DEPTH_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [mctt_pkg::MEAS_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [mctt_pkg::MEAS_W-1:0] rd_data
);

    logic [mctt_pkg::MEAS_W-1:0] mem [DEPTH];
    logic [mctt_pkg::MEAS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/midi_clock_tempo_tracker.sv
// Top level of the MIDI clock tempo tracker: sequencer, state and configuration registers.
// A poll or the first pulse after loss goes straight to the done state and reports when the output is free.
// A measured pulse runs the shared 22-step divider once for the measurement and once for the
// average, with a one-entry-per-cycle sweep of the n stored measurements (1 to depth) between.
// One transaction is processed at a time; reset clears control state and restores defaults.
module midi_clock_tempo_tracker
#(
    parameter int HISTORY_DEPTH = mctt_pkg::HISTORY_DEPTH_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  mctt_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output mctt_pkg::out_item_t              out_data,
    input  logic                             cfg_wr_en,
    input  logic [mctt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mctt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W  = mctt_pkg::MEAS_W + $clog2(HISTORY_DEPTH);

    mctt_pkg::state_t state_reg, state_next;

    logic [mctt_pkg::TEMPO_W-1:0] min_tempo_reg;
    logic [mctt_pkg::TEMPO_W-1:0] max_tempo_reg;
    logic [mctt_pkg::TIME_W-1:0]  timeout_reg;

    logic [mctt_pkg::TIME_W-1:0]  last_pulse_reg, last_pulse_next;
    logic [ADDR_W-1:0]            write_pos_reg, write_pos_next;
    logic [CNT_W-1:0]             pulse_count_reg, pulse_count_next;
    logic                         clock_seen_reg, clock_seen_next;
    logic [mctt_pkg::TEMPO_W-1:0] tempo_reg, tempo_next;
    logic                         updated_reg, updated_next;
    logic [ADDR_W-1:0]            sum_idx_reg, sum_idx_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0]             acc_reg, acc_next;
    logic                         out_valid_reg, out_valid_next;
    mctt_pkg::out_item_t          out_data_reg, out_data_next;

    logic                          in_accept;
    logic                          out_free;
    logic                          sum_last;
    logic [mctt_pkg::TIME_W-1:0]   gap;
    logic [mctt_pkg::MEAS_W-1:0]   meas;
    logic [mctt_pkg::DIVIDEND_W-1:0] avg;
    logic                          ring_wr_en;
    logic [mctt_pkg::MEAS_W-1:0]   ring_rd_data;
    mctt_pkg::div_req_t            div_req;
    mctt_pkg::div_rsp_t            div_rsp;

    assign in_stall  = (state_reg != mctt_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign gap       = in_data.time_us - last_pulse_reg;
    assign sum_last  = (CNT_W'(sum_idx_reg) + CNT_W'(1)) == pulse_count_reg;
    assign avg       = div_rsp.quotient;
    assign meas      = (div_rsp.quotient > mctt_pkg::DIVIDEND_W'(mctt_pkg::MEAS_MAX))
                       ? mctt_pkg::MEAS_MAX : div_rsp.quotient[mctt_pkg::MEAS_W-1:0];
    assign ring_wr_en = (state_reg == mctt_pkg::ST_MEAS) && div_rsp.done;

    mctt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mctt_ring
    #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (ADDR_W)
    )
    u_ring
    (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (write_pos_reg),
        .wr_data (meas),
        .rd_addr (sum_idx_reg),
        .rd_data (ring_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mctt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if ((in_data.opcode == mctt_pkg::OP_PULSE) && (pulse_count_reg != '0))
                    begin
                        state_next = mctt_pkg::ST_MEAS;
                    end
                    else
                    begin
                        state_next = mctt_pkg::ST_DONE;
                    end
                end
            end
            mctt_pkg::ST_MEAS:
            begin
                if (div_rsp.done)
                begin
                    state_next = mctt_pkg::ST_SUM;
                end
            end
            mctt_pkg::ST_SUM:
            begin
                if (sum_last)
                begin
                    state_next = mctt_pkg::ST_SUM_TAIL;
                end
            end
            mctt_pkg::ST_SUM_TAIL:
            begin
                state_next = mctt_pkg::ST_AVG;
            end
            mctt_pkg::ST_AVG:
            begin
                if (div_rsp.done)
                begin
                    state_next = mctt_pkg::ST_DONE;
                end
            end
            mctt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mctt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mctt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        last_pulse_next  = last_pulse_reg;
        write_pos_next   = write_pos_reg;
        pulse_count_next = pulse_count_reg;
        clock_seen_next  = clock_seen_reg;
        tempo_next       = tempo_reg;
        updated_next     = updated_reg;
        sum_idx_next     = sum_idx_reg;
        rd_pend_next     = rd_pend_reg;
        acc_next         = acc_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mctt_pkg::US_PER_QUARTER;
        div_req.divisor  = gap;

        unique case (state_reg)
            mctt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    updated_next = 1'b0;
                    if (in_data.opcode == mctt_pkg::OP_PULSE)
                    begin
                        clock_seen_next = 1'b1;
                        last_pulse_next = in_data.time_us;
                        if (pulse_count_reg == '0)
                        begin
                            pulse_count_next = CNT_W'(1);
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                        end
                    end
                    else if (gap > timeout_reg)
                    begin
                        clock_seen_next  = 1'b0;
                        pulse_count_next = '0;
                        write_pos_next   = '0;
                    end
                end
            end
            mctt_pkg::ST_MEAS:
            begin
                if (div_rsp.done)
                begin
                    if (write_pos_reg == ADDR_W'(HISTORY_DEPTH - 1))
                    begin
                        write_pos_next = '0;
                    end
                    else
                    begin
                        write_pos_next = write_pos_reg + ADDR_W'(1);
                    end
                    sum_idx_next = '0;
                    rd_pend_next = 1'b0;
                    acc_next     = '0;
                end
            end
            mctt_pkg::ST_SUM:
            begin
                rd_pend_next = 1'b1;
                if (rd_pend_reg)
                begin
                    acc_next = acc_reg + SUM_W'(ring_rd_data);
                end
                if (!sum_last)
                begin
                    sum_idx_next = sum_idx_reg + ADDR_W'(1);
                end
            end
            mctt_pkg::ST_SUM_TAIL:
            begin
                rd_pend_next     = 1'b0;
                acc_next         = acc_reg + SUM_W'(ring_rd_data);
                div_req.start    = 1'b1;
                div_req.dividend = mctt_pkg::DIVIDEND_W'(acc_next);
                div_req.divisor  = mctt_pkg::DIVISOR_W'(pulse_count_reg);
            end
            mctt_pkg::ST_AVG:
            begin
                if (div_rsp.done)
                begin
                    if ((avg != mctt_pkg::DIVIDEND_W'(tempo_reg))
                        && (avg >= mctt_pkg::DIVIDEND_W'(min_tempo_reg))
                        && (avg <= mctt_pkg::DIVIDEND_W'(max_tempo_reg)))
                    begin
                        tempo_next   = avg[mctt_pkg::TEMPO_W-1:0];
                        updated_next = 1'b1;
                    end
                    if (pulse_count_reg < CNT_W'(HISTORY_DEPTH))
                    begin
                        pulse_count_next = pulse_count_reg + CNT_W'(1);
                    end
                end
            end
            mctt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.clock_present = clock_seen_reg;
                    out_data_next.tempo_updated = updated_reg;
                    out_data_next.tempo         = tempo_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mctt_pkg::ST_IDLE;
            last_pulse_reg  <= '0;
            write_pos_reg   <= '0;
            pulse_count_reg <= '0;
            clock_seen_reg  <= 1'b0;
            tempo_reg       <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_pulse_reg  <= last_pulse_next;
            write_pos_reg   <= write_pos_next;
            pulse_count_reg <= pulse_count_next;
            clock_seen_reg  <= clock_seen_next;
            tempo_reg       <= tempo_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        updated_reg  <= updated_next;
        sum_idx_reg  <= sum_idx_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tempo_reg <= mctt_pkg::MIN_TEMPO_RST;
            max_tempo_reg <= mctt_pkg::MAX_TEMPO_RST;
            timeout_reg   <= mctt_pkg::TIMEOUT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mctt_pkg::REG_MIN_TEMPO:
                begin
                    min_tempo_reg <= cfg_data[mctt_pkg::TEMPO_W-1:0];
                end
                mctt_pkg::REG_MAX_TEMPO:
                begin
                    max_tempo_reg <= cfg_data[mctt_pkg::TEMPO_W-1:0];
                end
                mctt_pkg::REG_LOSS_TIMEOUT:
                begin
                    timeout_reg <= cfg_data[mctt_pkg::TIME_W-1:0];
                end
                default:
                begin
                    timeout_reg <= timeout_reg;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == mctt_pkg::ST_MEAS || state_reg == mctt_pkg::ST_AVG))
        else $error("divider finished outside a divide state");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_count_reg <= CNT_W'(HISTORY_DEPTH))
        && (32'(write_pos_reg) < 32'(HISTORY_DEPTH)))
        else $error("pulse count or write position out of range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != mctt_pkg::ST_IDLE))
        else $error("accepted transaction did not start processing");

    a_sum_before_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mctt_pkg::ST_SUM_TAIL) |-> (rd_pend_reg && div_req.start))
        else $error("average started without a pending history read");

endmodule

// File: tb/midi_clock_tempo_tracker_tb.sv
// Self-checking testbench for the MIDI clock tempo tracker with directed and random traffic.
`timescale 1ns / 1ps

module midi_clock_tempo_tracker_tb;

    localparam int          HISTORY            = mctt_pkg::HISTORY_DEPTH_DEFAULT;
    localparam logic [63:0] US_PER_MINUTE      = 64'd60000000;
    localparam logic [63:0] PULSES_PER_QUARTER = 64'd24;
    localparam int          CYCLE_LIMIT        = 1000000;
    localparam int          HOLD_CYCLES        = 400;
    localparam int          DRAIN_CYCLES       = 100;
    localparam int          PHASES             = 8;
    localparam int          HALF_PHASE_ITEMS   = 95;

    class tempo_scoreboard;
        logic [mctt_pkg::TEMPO_W-1:0] min_tempo;
        logic [mctt_pkg::TEMPO_W-1:0] max_tempo;
        logic [mctt_pkg::TIME_W-1:0]  loss_timeout;
        logic [mctt_pkg::TIME_W-1:0]  last_pulse_time;
        logic [mctt_pkg::MEAS_W-1:0]  history [HISTORY];
        int                           write_pos;
        int                           pulse_count;
        logic                         clock_seen;
        logic [mctt_pkg::TEMPO_W-1:0] current_tempo;
        mctt_pkg::out_item_t          pending_reports [$];
        int                           mismatch_count;

        function new();
            min_tempo       = mctt_pkg::MIN_TEMPO_RST;
            max_tempo       = mctt_pkg::MAX_TEMPO_RST;
            loss_timeout    = mctt_pkg::TIMEOUT_RST;
            last_pulse_time = '0;
            write_pos       = 0;
            pulse_count     = 0;
            clock_seen      = 1'b0;
            current_tempo   = '0;
            mismatch_count  = 0;
        endfunction

        function void set_register(logic [mctt_pkg::CFG_IDX_W-1:0] index,
                                   logic [mctt_pkg::CFG_DATA_W-1:0] value);
            case (index)
                mctt_pkg::REG_MIN_TEMPO:    min_tempo = value[mctt_pkg::TEMPO_W-1:0];
                mctt_pkg::REG_MAX_TEMPO:    max_tempo = value[mctt_pkg::TEMPO_W-1:0];
                mctt_pkg::REG_LOSS_TIMEOUT: loss_timeout = value;
                default:                    ;
            endcase
        endfunction

        function void note_event(mctt_pkg::in_item_t item);
            logic [mctt_pkg::TIME_W-1:0] gap;
            logic [63:0]                 denom;
            logic [63:0]                 quotient;
            int unsigned                 total;
            int unsigned                 average;
            int                          i;
            logic                        updated;
            mctt_pkg::out_item_t         report;
            updated = 1'b0;
            gap = item.time_us - last_pulse_time;
            if (item.opcode == mctt_pkg::OP_PULSE)
            begin
                clock_seen = 1'b1;
                if (pulse_count > 0)
                begin
                    denom = 64'(gap) * PULSES_PER_QUARTER;
                    if (denom == 0)
                    begin
                        history[write_pos] = mctt_pkg::MEAS_MAX;
                    end
                    else
                    begin
                        quotient = US_PER_MINUTE / denom;
                        history[write_pos] = (quotient > 64'(mctt_pkg::MEAS_MAX))
                                             ? mctt_pkg::MEAS_MAX
                                             : quotient[mctt_pkg::MEAS_W-1:0];
                    end
                    write_pos = (write_pos + 1) % HISTORY;
                    total = 0;
                    for (i = 0; i < pulse_count; i++)
                    begin
                        total += history[i];
                    end
                    average = total / pulse_count;
                    if (average != current_tempo && average >= min_tempo &&
                        average <= max_tempo)
                    begin
                        current_tempo = average[mctt_pkg::TEMPO_W-1:0];
                        updated = 1'b1;
                    end
                end
                last_pulse_time = item.time_us;
                if (pulse_count < HISTORY)
                begin
                    pulse_count++;
                end
            end
            else if (gap > loss_timeout)
            begin
                clock_seen  = 1'b0;
                pulse_count = 0;
                write_pos   = 0;
            end
            report.clock_present = clock_seen;
            report.tempo_updated = updated;
            report.tempo         = current_tempo;
            pending_reports.push_back(report);
        endfunction

        function void check_result(mctt_pkg::out_item_t actual);
            mctt_pkg::out_item_t expected;
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result: present=%0d updated=%0d tempo=%0d",
                             actual.clock_present, actual.tempo_updated, actual.tempo);
                end
            end
            else
            begin
                expected = pending_reports.pop_front();
                if (actual.clock_present !== expected.clock_present ||
                    actual.tempo_updated !== expected.tempo_updated ||
                    actual.tempo !== expected.tempo)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display({"result mismatch: expected present=%0d updated=%0d ",
                                  "tempo=%0d, got present=%0d updated=%0d tempo=%0d"},
                                 expected.clock_present, expected.tempo_updated,
                                 expected.tempo, actual.clock_present,
                                 actual.tempo_updated, actual.tempo);
                    end
                end
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    mctt_pkg::in_item_t              in_data;
    logic                            out_valid;
    logic                            out_stall;
    mctt_pkg::out_item_t             out_data;
    logic                            cfg_wr_en;
    logic [mctt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mctt_pkg::CFG_DATA_W-1:0] cfg_data;

    tempo_scoreboard             board = new();
    bit                          no_idle = 1'b0;
    bit                          hold_request = 1'b0;
    int                          cycle_count = 0;
    logic [mctt_pkg::TIME_W-1:0] stim_time;
    int unsigned                 beat_period;

    midi_clock_tempo_tracker u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                board.check_result(out_data);
                stall_left = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Must be entered at a rising edge; returns at the edge where the transaction is accepted.
    task automatic offer_event(input logic opcode, input logic [mctt_pkg::TIME_W-1:0] stamp);
        int gap;
        mctt_pkg::in_item_t item;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        item.opcode  = opcode;
        item.time_us = stamp;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        board.note_event(item);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [mctt_pkg::TEMPO_W-1:0] min_bpm,
                             input logic [mctt_pkg::TEMPO_W-1:0] max_bpm,
                             input logic [mctt_pkg::TIME_W-1:0] timeout);
        cfg_wr_en <= 1'b1;
        cfg_index <= mctt_pkg::REG_MIN_TEMPO;
        cfg_data  <= mctt_pkg::CFG_DATA_W'(min_bpm);
        @(posedge clk);
        cfg_index <= mctt_pkg::REG_MAX_TEMPO;
        cfg_data  <= mctt_pkg::CFG_DATA_W'(max_bpm);
        @(posedge clk);
        cfg_index <= mctt_pkg::REG_LOSS_TIMEOUT;
        cfg_data  <= timeout;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_register(mctt_pkg::REG_MIN_TEMPO, mctt_pkg::CFG_DATA_W'(min_bpm));
        board.set_register(mctt_pkg::REG_MAX_TEMPO, mctt_pkg::CFG_DATA_W'(max_bpm));
        board.set_register(mctt_pkg::REG_LOSS_TIMEOUT, timeout);
    endtask

    task automatic run_directed();
        offer_event(mctt_pkg::OP_POLL, 32'd0);
        offer_event(mctt_pkg::OP_POLL, 32'd600000);
        offer_event(mctt_pkg::OP_PULSE, 32'hFFFF_FFFF);
        offer_event(mctt_pkg::OP_PULSE, 32'h0000_5160);
        offer_event(mctt_pkg::OP_PULSE, 32'h0000_5160);
        offer_event(mctt_pkg::OP_PULSE, 32'h0000_5160 + 32'd20833);
        offer_event(mctt_pkg::OP_POLL, 32'h0000_5160 + 32'd520834);
        offer_event(mctt_pkg::OP_POLL, 32'h0000_5160 + 32'd520900);
        offer_event(mctt_pkg::OP_PULSE, 32'd1000000);
        offer_event(mctt_pkg::OP_PULSE, 32'd4000000);
        offer_event(mctt_pkg::OP_POLL, 32'd4500000);
        offer_event(mctt_pkg::OP_POLL, 32'd4500001);
        offer_event(mctt_pkg::OP_PULSE, 32'd0);
        offer_event(mctt_pkg::OP_PULSE, 32'd8334);
        offer_event(mctt_pkg::OP_PULSE, 32'd16667);
        offer_event(mctt_pkg::OP_PULSE, 32'd25000);
        offer_event(mctt_pkg::OP_POLL, 32'hFFFF_FFFF);
        offer_event(mctt_pkg::OP_PULSE, 32'h8000_0000);
        offer_event(mctt_pkg::OP_PULSE, 32'h8000_0000 + 32'd41667);
        offer_event(mctt_pkg::OP_PULSE, 32'h8000_0000 + 32'd83334);
        offer_event(mctt_pkg::OP_PULSE, 32'h8000_0000 + 32'd125001);
        offer_event(mctt_pkg::OP_POLL, 32'h8000_0000 + 32'd130000);
    endtask

    task automatic run_traffic(input int count);
        int                          n;
        int                          r;
        int                          jitter;
        int                          offset;
        logic [mctt_pkg::TIME_W-1:0] stamp;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 74)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       beat_period = $urandom_range(0, 3);
                        1:       beat_period = $urandom_range(2400, 3000000);
                        default: beat_period = 2500000 / $urandom_range(25, 400);
                    endcase
                end
                jitter = beat_period / 64;
                offset = int'($urandom_range(0, 2 * jitter)) - jitter;
                stamp = stim_time + mctt_pkg::TIME_W'(beat_period)
                        + mctt_pkg::TIME_W'(offset);
                stim_time = stamp;
                offer_event(mctt_pkg::OP_PULSE, stamp);
            end
            else if (r < 86)
            begin
                offer_event(mctt_pkg::OP_POLL,
                            stim_time + mctt_pkg::TIME_W'($urandom_range(0, beat_period)));
            end
            else if (r < 91)
            begin
                stamp = stim_time + board.loss_timeout + 32'd1 +
                        mctt_pkg::TIME_W'($urandom_range(0, 1000));
                stim_time = stamp;
                offer_event(mctt_pkg::OP_POLL, stamp);
            end
            else
            begin
                stamp = $urandom;
                if ($urandom_range(0, 1) == 0)
                begin
                    stim_time = stamp;
                    offer_event(mctt_pkg::OP_PULSE, stamp);
                end
                else
                begin
                    offer_event(mctt_pkg::OP_POLL, stamp);
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= mctt_pkg::REG_MIN_TEMPO;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            case (phase)
                0: configure(mctt_pkg::MIN_TEMPO_RST, mctt_pkg::MAX_TEMPO_RST,
                             mctt_pkg::TIMEOUT_RST);
                1: configure(10'd0, 10'd1023, 32'd1);
                2: configure(10'd1023, 10'd1023, 32'hFFFF_FFFF);
                3: configure(10'd400, 10'd100, 32'd100000);
                default:
                begin
                    configure(mctt_pkg::TEMPO_W'($urandom_range(0, 200)),
                              mctt_pkg::TEMPO_W'($urandom_range(150, 1023)),
                              ($urandom_range(0, 3) == 0) ? ($urandom | 32'd1)
                                                          : $urandom_range(20000, 2000000));
                end
            endcase
            no_idle = (phase == 5);
            stim_time = $urandom;
            beat_period = 2500000 / $urandom_range(25, 400);
            run_traffic(HALF_PHASE_ITEMS);
            if (phase == 2)
            begin
                hold_request = 1'b1;
            end
            if (phase == 3)
            begin
                wait_for_results();
            end
            run_traffic(HALF_PHASE_ITEMS);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatch_count == 0 && board.pending_reports.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
